// ----- rtl/permission_mode_spec_parser_macros.svh -----
// assertion macros for the mode specification parser
`ifndef PERMISSION_MODE_SPEC_PARSER_MACROS_SVH
`define PERMISSION_MODE_SPEC_PARSER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PMSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define PMSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/pmsp_pkg.sv -----
// shared types, constants and functions of the mode specification parser
package pmsp_pkg;

  localparam logic [8:0] ALL_BITS   = 9'o777;
  localparam logic [8:0] USER_BITS  = 9'o700;
  localparam logic [8:0] GROUP_BITS = 9'o070;
  localparam logic [8:0] OTHER_BITS = 9'o007;
  localparam logic [8:0] READ_BITS  = 9'o444;
  localparam logic [8:0] WRITE_BITS = 9'o222;
  localparam logic [8:0] EXEC_BITS  = 9'o111;

  localparam logic [2:0] MAX_DIGITS  = 3'd4;
  localparam logic [2:0] DIGIT_SATUR = 3'd5;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_SET = 2'd2
  } op_e;

  typedef struct packed {
    logic [7:0] spec_char;
    logic       is_last;
    logic [8:0] start_mode;
  } pmsp_in_t;

  typedef struct packed {
    logic [8:0] new_mode;
    logic       used_octal;
    logic       syntax_error;
  } pmsp_out_t;

  typedef struct packed {
    logic       at_string_start;
    logic       octal_valid;
    logic [8:0] octal_value;
    logic [2:0] octal_digit_count;
    logic       symbolic_valid;
    logic       clause_phase;
    logic [8:0] who_mask;
    logic [8:0] perm_bits;
    op_e        clause_operator;
    logic [8:0] working_mode;
  } parse_state_t;

  function automatic logic [8:0] apply_clause(input logic [8:0] who_mask,
                                              input logic [8:0] perm_bits,
                                              input op_e        op,
                                              input logic [8:0] mode);
    logic [8:0] who;
    logic [8:0] sel;
    logic [8:0] res;
    who = (who_mask == 9'd0) ? ALL_BITS : who_mask;
    sel = who & perm_bits;
    unique case (op)
      OP_ADD:  res = mode | sel;
      OP_SUB:  res = mode & ~sel;
      default: res = (mode & ~who) | sel;
    endcase
    return res & ALL_BITS;
  endfunction

endpackage

// ----- rtl/pmsp_step.sv -----
// per-character parse update for octal and symbolic grammars
module pmsp_step
  import pmsp_pkg::*;
(
  input  parse_state_t state_i,
  input  pmsp_in_t     in_i,
  output parse_state_t state_o,
  output pmsp_out_t    result_o,
  output logic         result_valid_o
);

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_O     = 8'h6f;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_W     = 8'h77;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_COMMA = 8'h2c;

  parse_state_t st;
  pmsp_out_t    res;
  logic         is_digit;

  always_comb begin
    st = state_i;
    if (state_i.at_string_start) begin
      st.octal_valid       = 1'b1;
      st.octal_value       = 9'd0;
      st.octal_digit_count = 3'd0;
      st.symbolic_valid    = 1'b1;
      st.clause_phase      = 1'b0;
      st.who_mask          = 9'd0;
      st.perm_bits         = 9'd0;
      st.clause_operator   = OP_ADD;
      st.working_mode      = in_i.start_mode;
    end

    // octal grammar
    is_digit = (in_i.spec_char >= CH_0) && (in_i.spec_char <= CH_7);
    if (!is_digit) begin
      st.octal_valid = 1'b0;
    end else begin
      st.octal_value = {st.octal_value[5:0], in_i.spec_char[2:0]};
      if (st.octal_digit_count < DIGIT_SATUR) begin
        st.octal_digit_count = st.octal_digit_count + 3'd1;
      end
      if (st.octal_digit_count > MAX_DIGITS) begin
        st.octal_valid = 1'b0;
      end
    end

    // symbolic grammar
    if (st.symbolic_valid) begin
      if (!st.clause_phase) begin
        case (in_i.spec_char) inside
          CH_U: st.who_mask = st.who_mask | USER_BITS;
          CH_G: st.who_mask = st.who_mask | GROUP_BITS;
          CH_O: st.who_mask = st.who_mask | OTHER_BITS;
          CH_A: st.who_mask = st.who_mask | ALL_BITS;
          CH_PLUS, CH_MINUS, CH_EQ: begin
            st.clause_operator = (in_i.spec_char == CH_PLUS)  ? OP_ADD :
                                 (in_i.spec_char == CH_MINUS) ? OP_SUB : OP_SET;
            st.perm_bits       = 9'd0;
            st.clause_phase    = 1'b1;
          end
          default: st.symbolic_valid = 1'b0;
        endcase
      end else begin
        case (in_i.spec_char)
          CH_R: st.perm_bits = st.perm_bits | READ_BITS;
          CH_W: st.perm_bits = st.perm_bits | WRITE_BITS;
          CH_X: st.perm_bits = st.perm_bits | EXEC_BITS;
          CH_COMMA: begin
            st.working_mode = apply_clause(st.who_mask, st.perm_bits,
                                           st.clause_operator, st.working_mode);
            st.who_mask     = 9'd0;
            st.perm_bits    = 9'd0;
            st.clause_phase = 1'b0;
          end
          default: st.symbolic_valid = 1'b0;
        endcase
      end
    end

    // result on the last character
    res = '0;
    if (st.octal_valid && (st.octal_digit_count >= 3'd1) &&
        (st.octal_digit_count <= MAX_DIGITS)) begin
      res.new_mode   = st.octal_value;
      res.used_octal = 1'b1;
    end else if (st.symbolic_valid && st.clause_phase) begin
      res.new_mode = apply_clause(st.who_mask, st.perm_bits,
                                  st.clause_operator, st.working_mode);
    end else begin
      res.syntax_error = 1'b1;
    end

    st.at_string_start = in_i.is_last;
  end

  assign state_o        = st;
  assign result_o       = res;
  assign result_valid_o = in_i.is_last;

endmodule

// ----- rtl/permission_mode_spec_parser.sv -----
// top level of the permission mode specification parser
// a final character's result passes through the input register and then the result register to the output
// accepts one character per cycle, stalling only when the result register is held
// the input register and result register each hold one transaction
// reset clears the pipeline; the first character after reset starts a new specification
// and samples start_mode
module permission_mode_spec_parser
  import pmsp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  pmsp_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output pmsp_out_t out_data_o
);

`include "permission_mode_spec_parser_macros.svh"

  logic         s1_valid_q;
  pmsp_in_t     s1_q;
  parse_state_t st_q;
  parse_state_t st_d;
  logic         out_valid_q;
  pmsp_out_t    out_q;
  pmsp_out_t    step_res;
  logic         step_res_valid;
  logic         res_ready;
  logic         s1_adv;
  logic         in_accept;

  pmsp_step u_step (
    .state_i        (st_q),
    .in_i           (s1_q),
    .state_o        (st_d),
    .result_o       (step_res),
    .result_valid_o (step_res_valid)
  );

  assign res_ready  = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && (!step_res_valid || res_ready);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '{at_string_start: 1'b1, octal_valid: 1'b1, octal_value: 9'd0,
                       octal_digit_count: 3'd0, symbolic_valid: 1'b1,
                       clause_phase: 1'b0, who_mask: 9'd0, perm_bits: 9'd0,
                       clause_operator: OP_ADD, working_mode: 9'd0};
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        st_q <= st_d;
      end
      if (s1_adv && step_res_valid) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= in_data_i;
    end
    if (s1_adv && step_res_valid) begin
      out_q <= step_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `PMSP_ASSERT_NOW(a_err_zero_mode, clk_i, rst_ni,
                   out_valid_q && out_q.syntax_error, out_q.new_mode == 9'd0)
  `PMSP_ASSERT_NOW(a_octal_not_err, clk_i, rst_ni,
                   out_valid_q, !(out_q.used_octal && out_q.syntax_error))
  `PMSP_ASSERT_NEXT(a_last_restarts, clk_i, rst_ni,
                    s1_adv && s1_q.is_last, st_q.at_string_start)

endmodule
